/* rtl/core/json_string_escaper_unit_assert.svh */
// assertion macros for the json string escaper
`ifndef JSON_STRING_ESCAPER_UNIT_ASSERT_SVH
`define JSON_STRING_ESCAPER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jse assertion failed");

// next-cycle implication, checked out of reset
`define JSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jse assertion failed");

`endif

/* rtl/core/jse_pkg.sv */
// types, constants and helper functions of the json string escaper
package jse_pkg;

  localparam int unsigned MaxResults = 8;
  localparam int unsigned IdxW       = $clog2(MaxResults);
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned CpW        = 21;

  localparam logic [7:0]     CtrlLimit = 8'h20;
  localparam logic [CpW-1:0] CpMax     = 21'h10ffff;
  localparam logic [7:0]     Solidus   = 8'h2f;
  localparam logic [7:0]     Backslash = 8'h5c;
  localparam logic [7:0]     Quote     = 8'h22;
  localparam logic [7:0]     LetterU   = 8'h75;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       error_flag;
    logic       last_of_run;
  } out_item_t;

  // escape letter of a one-byte character, zero when it has none
  function automatic logic [7:0] escape_of(input logic [7:0] b);
    logic [7:0] e;
    unique case (b)
      Quote:     e = Quote;
      Backslash: e = Backslash;
      Solidus:   e = Solidus;
      8'h08:     e = 8'h62;
      8'h0c:     e = 8'h66;
      8'h0a:     e = 8'h6e;
      8'h0d:     e = 8'h72;
      8'h09:     e = 8'h74;
      default:   e = 8'h00;
    endcase
    return e;
  endfunction

  // lowercase hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h57 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

/* rtl/core/json_string_escaper_unit.sv */
// json string escaper: utf-8 bytes in, escaped characters out one per cycle
// while the receiver does not stall
// Input channel in_item_i / in_valid_i / in_stall_o carries one source byte
// per item with an end-of-string flag on the last byte. Output channel
// out_item_o / out_valid_o / out_stall_i carries one escaped character per
// item; last_of_run marks the final result of an input byte, error_flag
// marks a dropped character (out_char is zero then).
// An accepted byte is decoded in the same cycle into a run of up to eight
// characters held in the run register; from there each character passes
// into the output register. The run register empties one character per
// cycle while the receiver does not stall, and a new byte is accepted in
// the cycle its predecessor's last character moves out. Plain bytes and
// bytes that give no result (lead and middle bytes) go at one per cycle
// while the receiver does not stall; a byte that gives a named escape or a
// \u escape holds the input until its whole run has moved out.
// Reset clears the partial code point, the run register and the output
// register valid. When the receiver stalls, the output item holds, the run
// register stops, and in_stall_o rises once the run register is still full.
module json_string_escaper_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jse_pkg::in_item_t    in_item_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output jse_pkg::out_item_t   out_item_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i
);

  // decoder state
  logic [1:0]              br_q, br_d;
  logic [jse_pkg::CpW-1:0] acc_q, acc_d;

  // run register
  logic                    run_valid_q, run_valid_d;
  logic                    run_err_q;
  logic [7:0]              run_chars_q [jse_pkg::MaxResults];
  logic [jse_pkg::IdxW-1:0] run_idx_q, run_idx_d;
  logic [jse_pkg::IdxW-1:0] run_last_q;

  // output register
  logic                    out_valid_q, out_valid_d;
  jse_pkg::out_item_t      out_q;

  // decode results
  logic [7:0]              dec_chars [jse_pkg::MaxResults];
  logic [jse_pkg::CntW-1:0] dec_n;
  logic                    dec_err;
  logic [1:0]              dec_br;
  logic [jse_pkg::CpW-1:0] dec_acc;
  logic [jse_pkg::CpW-1:0] cp;
  logic [23:0]             cp24;
  logic [2:0]              ndig;
  logic [7:0]              esc;
  logic [7:0]              b;
  logic                    eos;

  logic in_acc, load_run, out_free, emit, run_done;

  assign b    = in_item_i.in_byte;
  assign eos  = in_item_i.end_of_string;
  assign cp   = {acc_q[jse_pkg::CpW-7:0], b[5:0]};
  assign cp24 = {3'b000, cp};
  assign esc  = jse_pkg::escape_of(b);

  always_comb begin
    dec_n   = '0;
    dec_err = 1'b0;
    dec_br  = br_q;
    dec_acc = acc_q;
    ndig    = 3'd4;
    for (int k = 0; k < jse_pkg::MaxResults; k++) begin
      dec_chars[k] = 8'h00;
    end
    if (br_q == 2'd0) begin
      if (!b[7]) begin
        if (esc != 8'h00) begin
          dec_n        = jse_pkg::CntW'(2);
          dec_chars[0] = jse_pkg::Backslash;
          dec_chars[1] = esc;
        end else if (b < jse_pkg::CtrlLimit) begin
          dec_n   = jse_pkg::CntW'(1);
          dec_err = 1'b1;
        end else begin
          dec_n        = jse_pkg::CntW'(1);
          dec_chars[0] = b;
        end
      end else if (b[7:5] == 3'b110) begin
        dec_acc = {16'h0000, b[4:0]};
        dec_br  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        dec_acc = {17'h00000, b[3:0]};
        dec_br  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        dec_acc = {18'h00000, b[2:0]};
        dec_br  = 2'd3;
      end else begin
        dec_n   = jse_pkg::CntW'(1);
        dec_err = 1'b1;
      end
      // lead byte cut short by the end of the string
      if (dec_br != 2'd0 && eos) begin
        dec_n   = jse_pkg::CntW'(1);
        dec_err = 1'b1;
      end
    end else begin
      dec_acc = cp;
      dec_br  = br_q - 2'd1;
      if (dec_br == 2'd0) begin
        dec_acc = '0;
        if (cp < {13'h0000, jse_pkg::CtrlLimit} || cp > jse_pkg::CpMax) begin
          dec_n   = jse_pkg::CntW'(1);
          dec_err = 1'b1;
        end else begin
          if (cp > 21'h0fffff) begin
            ndig = 3'd6;
          end else if (cp > 21'h00ffff) begin
            ndig = 3'd5;
          end
          dec_n        = jse_pkg::CntW'(ndig) + jse_pkg::CntW'(2);
          dec_chars[0] = jse_pkg::Backslash;
          dec_chars[1] = jse_pkg::LetterU;
          case (ndig)
            3'd6: begin
              for (int k = 0; k < 6; k++) begin
                dec_chars[2+k] = jse_pkg::hex_digit(cp24[4*(5-k) +: 4]);
              end
            end
            3'd5: begin
              for (int k = 0; k < 5; k++) begin
                dec_chars[2+k] = jse_pkg::hex_digit(cp24[4*(4-k) +: 4]);
              end
            end
            default: begin
              for (int k = 0; k < 4; k++) begin
                dec_chars[2+k] = jse_pkg::hex_digit(cp24[4*(3-k) +: 4]);
              end
            end
          endcase
        end
      end else if (eos) begin
        dec_n   = jse_pkg::CntW'(1);
        dec_err = 1'b1;
      end
    end
    if (eos) begin
      dec_br  = 2'd0;
      dec_acc = '0;
    end
  end

  // handshake and run control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = run_valid_q && out_free;
  assign run_done   = emit && (run_idx_q == run_last_q);
  assign in_stall_o = run_valid_q && !run_done;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_run   = in_acc && (dec_n != '0);

  always_comb begin
    br_d        = in_acc ? dec_br : br_q;
    acc_d       = in_acc ? dec_acc : acc_q;
    run_valid_d = run_valid_q;
    run_idx_d   = run_idx_q;
    if (load_run) begin
      run_valid_d = 1'b1;
      run_idx_d   = '0;
    end else if (emit) begin
      run_valid_d = !run_done;
      run_idx_d   = run_idx_q + jse_pkg::IdxW'(1);
    end
    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q        <= 2'd0;
      acc_q       <= '0;
      run_valid_q <= 1'b0;
      run_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      br_q        <= br_d;
      acc_q       <= acc_d;
      run_valid_q <= run_valid_d;
      run_idx_q   <= run_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_run) begin
      run_chars_q <= dec_chars;
      run_err_q   <= dec_err;
      run_last_q  <= jse_pkg::IdxW'(dec_n - jse_pkg::CntW'(1));
    end
    if (emit) begin
      out_q.out_char    <= run_err_q ? 8'h00 : run_chars_q[run_idx_q];
      out_q.error_flag  <= run_err_q;
      out_q.last_of_run <= (run_idx_q == run_last_q);
    end
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

`include "json_string_escaper_unit_assert.svh"

  // a new run only lands in an empty or emptying run register
  `JSE_ASSERT_NOW(a_run_no_overwrite, load_run, !run_valid_q || run_done)
  // an error result is a single zero character that ends its run
  `JSE_ASSERT_NOW(a_err_shape, out_valid_q && out_q.error_flag,
                  out_q.out_char == 8'h00 && out_q.last_of_run)
  // the read index never runs past the end of the run
  `JSE_ASSERT_NOW(a_idx_in_run, run_valid_q, run_idx_q <= run_last_q)
  // the end of a string always leaves the decoder idle
  `JSE_ASSERT_NEXT(a_eos_idle, in_acc && eos, br_q == 2'd0 && acc_q == '0)

endmodule

/* dv/json_string_escaper_unit_test.sv */
// self-checking testbench of the json string escaper: directed strings, then random utf-8 traffic
module json_string_escaper_unit_test;

  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned RandomItems = 365;
  localparam int unsigned EndCycles   = 20;

  localparam logic [7:0] HexDigit [16] = '{
    "0", "1", "2", "3", "4", "5", "6", "7",
    "8", "9", "a", "b", "c", "d", "e", "f"
  };
  localparam logic [7:0] NamedEscByte [8] = '{
    jse_pkg::Quote, jse_pkg::Backslash, jse_pkg::Solidus,
    8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  jse_pkg::in_item_t  in_item_i   = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  jse_pkg::out_item_t out_item_o;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;

  json_string_escaper_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state: open utf-8 sequence
  logic [1:0]  open_left  = '0;
  logic [2:0]  open_len   = '0;
  logic [20:0] partial_cp = '0;

  jse_pkg::out_item_t escaped_q [$];
  jse_pkg::out_item_t run_q [$];
  logic [7:0]         src_bytes [$];

  int unsigned bytes_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  bit          sender_eager   = 1'b0;
  bit          receiver_eager = 1'b0;
  bit          hold_output    = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_result(input logic [7:0] ch, input logic err);
    jse_pkg::out_item_t r;
    r.out_char    = ch;
    r.error_flag  = err;
    r.last_of_run = 1'b0;
    run_q.push_back(r);
  endfunction

  function automatic void clear_sequence();
    open_left  = '0;
    open_len   = '0;
    partial_cp = '0;
  endfunction

  // escaped characters caused by one source byte, appended to escaped_q
  function automatic void predict_escape(input jse_pkg::in_item_t it);
    logic [7:0]         b;
    logic [7:0]         esc;
    logic [20:0]        cp;
    logic [3:0]         nib;
    int                 ndig;
    int                 d;
    jse_pkg::out_item_t r;
    b = it.in_byte;
    run_q.delete();
    if (open_left == 2'd0) begin
      if (!b[7]) begin
        case (b) inside
          jse_pkg::Quote, jse_pkg::Backslash, jse_pkg::Solidus: esc = b;
          8'h08:   esc = "b";
          8'h0c:   esc = "f";
          8'h0a:   esc = "n";
          8'h0d:   esc = "r";
          8'h09:   esc = "t";
          default: esc = 8'h00;
        endcase
        if (esc != 8'h00) begin
          add_result(jse_pkg::Backslash, 1'b0);
          add_result(esc, 1'b0);
        end else if (b < jse_pkg::CtrlLimit) begin
          add_result(8'h00, 1'b1);
        end else begin
          add_result(b, 1'b0);
        end
      end else if (b[7:5] == 3'b110) begin
        partial_cp = {16'h0, b[4:0]};
        open_left  = 2'd1;
        open_len   = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        partial_cp = {17'h0, b[3:0]};
        open_left  = 2'd2;
        open_len   = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        partial_cp = {18'h0, b[2:0]};
        open_left  = 2'd3;
        open_len   = 3'd4;
      end else begin
        add_result(8'h00, 1'b1);
      end
      // lead byte carrying the end flag
      if (open_left != 2'd0 && it.end_of_string) begin
        add_result(8'h00, 1'b1);
        clear_sequence();
      end
    end else begin
      // top bits of a continuation byte are ignored
      partial_cp = {partial_cp[14:0], b[5:0]};
      open_left  = open_left - 2'd1;
      if (open_left == 2'd0) begin
        cp = partial_cp;
        if (cp < 21'(jse_pkg::CtrlLimit) || cp > jse_pkg::CpMax) begin
          add_result(8'h00, 1'b1);
        end else begin
          ndig = (cp > 21'hfffff) ? 6 : (cp > 21'hffff) ? 5 : 4;
          add_result(jse_pkg::Backslash, 1'b0);
          add_result(jse_pkg::LetterU, 1'b0);
          for (d = ndig - 1; d >= 0; d--) begin
            nib = 4'(cp >> (4 * d));
            add_result(HexDigit[nib], 1'b0);
          end
        end
        clear_sequence();
      end else if (it.end_of_string) begin
        add_result(8'h00, 1'b1);
        clear_sequence();
      end
    end
    if (it.end_of_string) clear_sequence();
    foreach (run_q[i]) begin
      r = run_q[i];
      r.last_of_run = (i == run_q.size() - 1);
      escaped_q.push_back(r);
    end
  endfunction

  // utf-8 encoding of cp in nb bytes, only ncont continuation bytes, some with random top bits
  function automatic void push_utf8(input logic [20:0] cp, input int nb, input int ncont);
    logic [7:0] c;
    int         i;
    case (nb)
      2:       src_bytes.push_back({3'b110, cp[10:6]});
      3:       src_bytes.push_back({4'b1110, cp[15:12]});
      default: src_bytes.push_back({5'b11110, cp[20:18]});
    endcase
    for (i = 0; i < ncont; i++) begin
      c = {2'b10, 6'(cp >> (6 * (nb - 2 - i)))};
      if ($urandom_range(0, 15) == 0) c[7:6] = 2'($urandom_range(0, 3));
      src_bytes.push_back(c);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned       gap;
    jse_pkg::in_item_t it;
    gap = sender_eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.in_byte       = b;
    it.end_of_string = eos;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    predict_escape(it);
  endtask

  task automatic send_string();
    foreach (src_bytes[i]) send_byte(src_bytes[i], i == src_bytes.size() - 1);
    src_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (escaped_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input jse_pkg::out_item_t got,
                                 input jse_pkg::out_item_t want);
    $display("mismatch: %s: got char %h err %b last %b, want char %h err %b last %b",
             what, got.out_char, got.error_flag, got.last_of_run,
             want.out_char, want.error_flag, want.last_of_run);
    mismatches++;
  endtask

  // compare every accepted output item with the oldest predicted character
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (escaped_q.size() == 0) begin
        report_mismatch("item with nothing pending", out_item_o, '0);
      end else if (out_item_o !== escaped_q[0]) begin
        report_mismatch("wrong item", out_item_o, escaped_q.pop_front());
      end else begin
        void'(escaped_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("watchdog: no item moved for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, stall-free stretches, and one long hold on request
  initial begin
    int unsigned n;
    forever begin
      if (hold_output) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_output = 1'b0;
      end else if (receiver_eager) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  task automatic test_ascii_escapes();
    // control byte error, every named escape
    src_bytes = '{8'h00, jse_pkg::Quote, jse_pkg::Backslash, jse_pkg::Solidus,
                  8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09};
    send_string();
  endtask

  task automatic test_multibyte_chars();
    src_bytes = '{8'hc2, 8'ha9};
    send_string();
    // five hex digits
    src_bytes = '{8'hf0, 8'h9f, 8'h98, 8'h80};
    send_string();
    // highest code point, six hex digits
    src_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_string();
  endtask

  task automatic test_invalid_input();
    // above the unicode range
    src_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
    send_string();
    // overlong form of a control code, then a bad byte and a stray continuation byte
    src_bytes = '{8'hc0, 8'h80, 8'hff, 8'h80};
    send_string();
    // cut short in the middle, then on the lead
    src_bytes = '{8'he2, 8'h82};
    send_string();
    src_bytes = '{8'hf0};
    send_string();
  endtask

  task automatic test_output_hold();
    int i;
    sender_eager = 1'b1;
    hold_output  = 1'b1;
    for (i = 0; i < 12; i++) begin
      push_utf8(21'($urandom_range(32'h10000, 32'h10ffff)), 4, 3);
    end
    send_string();
    wait_drained();
    sender_eager = 1'b0;
  endtask

  task automatic test_drain_pause();
    src_bytes = '{8'he2, 8'h82, 8'hac, 8'h41};
    send_string();
    wait_drained();
    src_bytes = '{8'h5c, 8'hc3, 8'ha9};
    send_string();
  endtask

  task automatic test_random_strings();
    int unsigned target;
    int unsigned kind;
    int          nchars;
    int          nb;
    int          i;
    target = bytes_sent + RandomItems;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 9) == 0) sender_eager = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) receiver_eager = ($urandom_range(0, 2) == 0);
      nchars = $urandom_range(1, 8);
      for (i = 0; i < nchars; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          src_bytes.push_back(8'($urandom_range(32, 127)));
        end else if (kind < 40) begin
          src_bytes.push_back(NamedEscByte[$urandom_range(0, 7)]);
        end else if (kind < 46) begin
          src_bytes.push_back(8'($urandom_range(0, 31)));
        end else if (kind < 62) begin
          push_utf8(21'($urandom_range(32'h80, 32'h7ff)), 2, 1);
        end else if (kind < 76) begin
          push_utf8(21'($urandom_range(32'h800, 32'hffff)), 3, 2);
        end else if (kind < 88) begin
          // some beyond the unicode range
          if ($urandom_range(0, 4) == 0) begin
            push_utf8(21'($urandom_range(32'h110000, 32'h1fffff)), 4, 3);
          end else begin
            push_utf8(21'($urandom_range(32'h10000, 32'h10ffff)), 4, 3);
          end
        end else if (kind < 95) begin
          src_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          // broken sequence
          nb = $urandom_range(2, 4);
          push_utf8(21'($urandom_range(0, 32'h1fffff)), nb, $urandom_range(0, nb - 2));
        end
      end
      send_string();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ascii_escapes();
    test_multibyte_chars();
    test_invalid_input();
    test_output_hold();
    test_drain_pause();
    test_random_strings();
    wait_drained();
    repeat (EndCycles) @(posedge clk_i);
    if (mismatches == 0 && escaped_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
